### sv/multichannel_event_rate_meter_assert.svh
// assertion macros for the event rate meter
`ifndef MULTICHANNEL_EVENT_RATE_METER_ASSERT_SVH
`define MULTICHANNEL_EVENT_RATE_METER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MCERM_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("event rate meter check failed");

// next-cycle implication, checked out of reset
`define MCERM_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("event rate meter check failed");

`endif

### sv/mcerm_pkg.sv
// shared types and constants of the event rate meter
`default_nettype none
package mcerm_pkg;

   localparam int CHANNELS_DEFAULT   = 32;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int CHANNEL_BITS       = 5;
   localparam int SCALE_BITS         = 10;
   localparam int RATE_BITS          = 26;
   localparam int OP_BITS            = 2;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 10'd5;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_REGISTER = 2'd0;
   localparam logic [OP_BITS-1:0] OP_COUNT    = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TICK     = 2'd2;

   // result kind and status codes
   localparam logic KIND_REGISTER = 1'b0;
   localparam logic KIND_RATE     = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef struct packed {
      logic [OP_BITS-1:0]      operation;
      logic [CHANNEL_BITS-1:0] channel;
   } req_type;

   typedef struct packed {
      logic                    kind;
      logic                    status;
      logic [CHANNEL_BITS-1:0] channel_id;
      logic [RATE_BITS-1:0]    rate;
      logic                    last;
   } rsp_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                    do_count;
      logic                    do_claim;
      logic                    shift;
      logic [CHANNEL_BITS-1:0] channel;
   } cell_ctrl_type;

endpackage
`default_nettype wire

### sv/multichannel_event_rate_meter.sv
// top level of the multichannel event rate meter
`default_nettype none
// Register and count transactions are taken only while the block is idle; a
// count transaction is taken even while a result waits on a stalled output.
// A tick walks the pool by rotating the chain of channel cells one place per
// cycle while the output is not stalled, past the rate multiplier at cell 0,
// and emits one report per registered channel.
// Each result appears in the output register the cycle after it is formed.
// rate_scale may be written only while the block is idle.
module multichannel_event_rate_meter #(
   parameter int CHANNELS   = mcerm_pkg::CHANNELS_DEFAULT,
   parameter int COUNT_BITS = mcerm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mcerm_pkg::req_type              req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mcerm_pkg::rsp_type              rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [mcerm_pkg::SCALE_BITS-1:0] csr_write_data
);
   import mcerm_pkg::*;

   `include "multichannel_event_rate_meter_assert.svh"

   localparam int POOL      = (CHANNELS < 32) ? CHANNELS : 32;
   localparam int STEP_BITS = (POOL > 1) ? $clog2(POOL) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_TICK = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [POOL-1:0]         rem_ff, rem_in;
   logic [SCALE_BITS-1:0]   scale_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_payload_ff, rsp_payload_in;

   logic                    out_free;
   logic                    req_fire;
   logic                    tick_step;
   cell_ctrl_type           ctrl;
   logic [POOL:0]           found;
   logic [POOL-1:0]         claim_vec;
   logic [POOL-1:0]         used_vec;
   logic [COUNT_BITS-1:0]   count_vec [POOL];
   logic [CHANNEL_BITS-1:0] claim_id;
   logic [RATE_BITS-1:0]    rate0;

   // handshake
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) ||
                      (~out_free && (req_payload.operation != OP_COUNT));
   assign req_fire  = req_valid & ~req_stall;
   assign tick_step = (state_ff == ST_TICK) & out_free;

   // cell control broadcast
   always_comb begin
      ctrl.do_count = req_fire && (req_payload.operation == OP_COUNT);
      ctrl.do_claim = req_fire && (req_payload.operation == OP_REGISTER);
      ctrl.shift    = tick_step;
      ctrl.channel  = req_payload.channel;
   end

   // chain of channel cells, rotating toward cell 0 during a tick
   assign found[0] = 1'b0;
   for (genvar i = 0; i < POOL; i++) begin : g_cell
      if (i == POOL - 1) begin : g_end
         mcerm_cell #(.INDEX(i), .COUNT_BITS(COUNT_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .claim      (claim_vec[i]),
            .next_used  (used_vec[0]),
            .next_count ({COUNT_BITS{1'b0}}),
            .used       (used_vec[i]),
            .count      (count_vec[i])
         );
      end else begin : g_mid
         mcerm_cell #(.INDEX(i), .COUNT_BITS(COUNT_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .claim      (claim_vec[i]),
            .next_used  (used_vec[i+1]),
            .next_count (count_vec[i+1]),
            .used       (used_vec[i]),
            .count      (count_vec[i])
         );
      end
   end

   // index of the claimed cell
   always_comb begin
      claim_id = '0;
      for (int i = 0; i < POOL; i++) begin
         if (claim_vec[i]) claim_id = claim_id | CHANNEL_BITS'(i);
      end
   end

   // rate of the channel sitting in cell 0
   mcerm_scale #(.COUNT_BITS(COUNT_BITS)) u_scale (
      .count (count_vec[0]),
      .scale (scale_ff),
      .rate  (rate0)
   );

   // tick walker and result selection
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      rem_in         = rem_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (out_free) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_payload.operation == OP_REGISTER)) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.kind       = KIND_REGISTER;
               rsp_payload_in.status     = found[POOL] ? STATUS_OK : STATUS_FULL;
               rsp_payload_in.channel_id = claim_id;
               rsp_payload_in.rate       = '0;
               rsp_payload_in.last       = 1'b1;
            end else if (req_fire && (req_payload.operation == OP_TICK)) begin
               state_in = ST_TICK;
               step_in  = '0;
               rem_in   = used_vec;
            end
         end
         ST_TICK: begin
            if (tick_step) begin
               if (used_vec[0]) begin
                  rsp_valid_in              = 1'b1;
                  rsp_payload_in.kind       = KIND_RATE;
                  rsp_payload_in.status     = STATUS_OK;
                  rsp_payload_in.channel_id = CHANNEL_BITS'(step_ff);
                  rsp_payload_in.rate       = rate0;
                  rsp_payload_in.last       = ~|(rem_ff >> 1);
               end
               rem_in  = rem_ff >> 1;
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_BITS'(POOL - 1)) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rem_ff       <= '0;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) scale_ff <= csr_write_data;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   `MCERM_ASSERT_NXT(a_reg_answer, req_fire && (req_payload.operation == OP_REGISTER), rsp_valid_ff && (rsp_payload_ff.kind == KIND_REGISTER) && rsp_payload_ff.last)
   `MCERM_ASSERT_NXT(a_tick_end, tick_step && (step_ff == STEP_BITS'(POOL - 1)), state_ff == ST_IDLE)
   `MCERM_ASSERT_IMP(a_walk_mask, state_ff == ST_TICK, used_vec[0] == rem_ff[0])

endmodule
`default_nettype wire

### sv/mcerm_cell.sv
// one channel cell: in-use flag and saturating event counter
`default_nettype none
module mcerm_cell #(
   parameter int INDEX      = 0,
   parameter int COUNT_BITS = mcerm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mcerm_pkg::cell_ctrl_type  ctrl,
   input  logic                      found_in,
   output logic                      found_out,
   output logic                      claim,
   input  logic                      next_used,
   input  logic [COUNT_BITS-1:0]     next_count,
   output logic                      used,
   output logic [COUNT_BITS-1:0]     count
);
   import mcerm_pkg::*;

   logic                  used_ff, used_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  hit;

   // free-slot search ripples from cell 0 upward
   assign found_out = found_in | ~used_ff;
   assign claim     = ctrl.do_claim & ~found_in & ~used_ff;

   // event lands here if registered and not saturated
   assign hit = ctrl.do_count && (ctrl.channel == CHANNEL_BITS'(INDEX)) && used_ff &&
                (count_ff != {COUNT_BITS{1'b1}});

   // next state: rotate during a tick, else claim or count
   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      priority if (ctrl.shift) begin
         used_in  = next_used;
         count_in = next_count;
      end else if (claim) begin
         used_in = 1'b1;
      end else if (hit) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   assign used  = used_ff;
   assign count = count_ff;

endmodule
`default_nettype wire

### sv/mcerm_scale.sv
// count times scale with saturation to the rate width
`default_nettype none
module mcerm_scale #(
   parameter int COUNT_BITS = mcerm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic [COUNT_BITS-1:0]           count,
   input  logic [mcerm_pkg::SCALE_BITS-1:0] scale,
   output logic [mcerm_pkg::RATE_BITS-1:0]  rate
);
   import mcerm_pkg::*;

   localparam int PROD_BITS = COUNT_BITS + SCALE_BITS;
   localparam int WIDE_BITS = (PROD_BITS > RATE_BITS) ? PROD_BITS : RATE_BITS;

   logic [PROD_BITS-1:0] product;
   logic [WIDE_BITS-1:0] wide;

   // one narrow multiply, then clamp
   assign product = PROD_BITS'(count) * PROD_BITS'(scale);
   assign wide    = WIDE_BITS'(product);
   assign rate    = (wide > WIDE_BITS'({RATE_BITS{1'b1}})) ? {RATE_BITS{1'b1}}
                                                          : RATE_BITS'(wide);

endmodule
`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the multichannel event rate meter
`timescale 1ns / 1ps

module testbench;
   import mcerm_pkg::*;

   localparam int POOL = 32;
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
   localparam logic [35:0] RATE_TOP = 36'((64'd1 << RATE_BITS) - 1);
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int GAP_MAX = 18;
   // a tick walks the whole pool, so it can keep the block busy this long
   localparam int SETTLE_CYCLES = 40;
   // longest quiet stretch: the long receiver hold-off plus margin
   localparam int LONG_HOLD = 400;
   localparam int QUIET_LIMIT = 2000;
   localparam int BURST_COUNTS = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [SCALE_BITS-1:0] csr_write_data = '0;

   multichannel_event_rate_meter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pending request transactions and the gap before each one
   req_type pending_req [$];
   int pending_gap [$];
   // rate reports and registration answers still to come
   rsp_type expected_rsp [$];

   // mirror of the channel pool
   logic claimed [POOL];
   logic [COUNT_BITS-1:0] tally [POOL];
   logic [SCALE_BITS-1:0] scale_now = SCALE_RESET;

   int phase_id = 0;
   int planned_claims = 0;
   bit sender_eager = 1'b0;
   bit rsp_eager = 1'b0;
   int req_taken = 0;
   int rsp_seen = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   // expected results of one accepted request
   task automatic predict_results(input req_type item);
      rsp_type r;
      int i;
      int top;
      bit found;
      logic [35:0] product;
      case (item.operation)
         OP_REGISTER: begin
            r = '0;
            r.kind = KIND_REGISTER;
            r.status = STATUS_FULL;
            r.last = 1'b1;
            found = 1'b0;
            for (i = 0; i < POOL; i++) begin
               if (!found && !claimed[i]) begin
                  claimed[i] = 1'b1;
                  r.status = STATUS_OK;
                  r.channel_id = CHANNEL_BITS'(i);
                  found = 1'b1;
               end
            end
            expected_rsp.push_back(r);
         end
         OP_COUNT: begin
            if (claimed[item.channel] && tally[item.channel] != COUNT_TOP)
               tally[item.channel] = tally[item.channel] + 1'b1;
         end
         OP_TICK: begin
            top = -1;
            for (i = 0; i < POOL; i++)
               if (claimed[i]) top = i;
            for (i = 0; i < POOL; i++) begin
               if (claimed[i]) begin
                  product = 36'(tally[i]) * 36'(scale_now);
                  r = '0;
                  r.kind = KIND_RATE;
                  r.status = STATUS_OK;
                  r.channel_id = CHANNEL_BITS'(i);
                  r.rate = (product > RATE_TOP) ? RATE_TOP[RATE_BITS-1:0]
                                                : product[RATE_BITS-1:0];
                  r.last = (i == top);
                  expected_rsp.push_back(r);
                  tally[i] = '0;
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // request driver
   int gap_left = 0;
   bit gap_armed = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_armed = 1'b0;
         for (int i = 0; i < POOL; i++) begin
            claimed[i] = 1'b0;
            tally[i] = '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            predict_results(req_payload);
            req_taken++;
         end
         // a stalled transaction stays as it is
         if (!(req_valid && req_stall)) begin
            if (pending_req.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               if (!gap_armed) begin
                  gap_left = pending_gap.pop_front();
                  gap_armed = 1'b1;
               end
               if (gap_left > 0) begin
                  gap_left--;
                  req_valid <= 1'b0;
               end else begin
                  req_payload <= pending_req.pop_front();
                  req_valid <= 1'b1;
                  gap_armed = 1'b0;
               end
            end
         end
      end
   end

   // result monitor and receiver stall
   int hold_left = 0;
   int long_hold_left = 0;
   bit long_hold_done = 1'b0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("result %0d: extra, kind %0b st %0b id %0d rate %0d last %0b",
                           rsp_seen, rsp_payload.kind, rsp_payload.status,
                           rsp_payload.channel_id, rsp_payload.rate, rsp_payload.last);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload.kind !== want.kind || rsp_payload.status !== want.status ||
                   rsp_payload.channel_id !== want.channel_id ||
                   rsp_payload.rate !== want.rate || rsp_payload.last !== want.last) begin
                  if (fail_count < 10) begin
                     $display("result %0d: want kind %0b st %0b id %0d rate %0d last %0b",
                              rsp_seen, want.kind, want.status, want.channel_id,
                              want.rate, want.last);
                     $display("result %0d: got  kind %0b st %0b id %0d rate %0d last %0b",
                              rsp_seen, rsp_payload.kind, rsp_payload.status,
                              rsp_payload.channel_id, rsp_payload.rate,
                              rsp_payload.last);
                  end
                  fail_count++;
               end
            end
            hold_left = rsp_eager ? 0 : $urandom_range(0, GAP_MAX);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         // one long hold-off so the block backs up into its input
         if (phase_id == 5 && !long_hold_done) begin
            long_hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (long_hold_left > 0) begin
            long_hold_left--;
         end
         rsp_stall <= (hold_left > 0) || (long_hold_left > 0);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d cycles without a transaction", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // queue one request transaction
   task automatic offer(input logic [OP_BITS-1:0] op, input logic [CHANNEL_BITS-1:0] ch);
      req_type item;
      item.operation = op;
      item.channel = ch;
      pending_req.push_back(item);
      pending_gap.push_back(sender_eager ? 0 : $urandom_range(0, GAP_MAX));
      if (op == OP_REGISTER && planned_claims < POOL) planned_claims++;
   endtask

   // random mix: mostly counts on claimed channels, some noise
   task automatic offer_random(input int n, input int reg_pct, input int tick_pct);
      int pick;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < reg_pct)
            offer(OP_REGISTER, CHANNEL_BITS'($urandom));
         else if (pick < reg_pct + tick_pct)
            offer(OP_TICK, CHANNEL_BITS'($urandom));
         else if (pick < reg_pct + tick_pct + 4)
            offer(OP_UNUSED, CHANNEL_BITS'($urandom));
         else if (planned_claims > 0 && $urandom_range(0, 99) < 85)
            offer(OP_COUNT, CHANNEL_BITS'($urandom_range(0, planned_claims - 1)));
         else
            offer(OP_COUNT, CHANNEL_BITS'($urandom));
      end
   endtask

   task automatic write_scale(input logic [SCALE_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      scale_now = value;
   endtask

   // wait until every transaction is out, then let the block settle
   task automatic wait_idle();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pool, unclaimed channels, unused code, first claims
      @(negedge clock);
      phase_id = 1;
      offer(OP_TICK, 5'd0);
      offer(OP_COUNT, 5'd0);
      offer(OP_COUNT, 5'd31);
      offer(OP_UNUSED, 5'd31);
      offer(OP_UNUSED, 5'd0);
      offer(OP_REGISTER, 5'd31);
      offer(OP_COUNT, 5'd0);
      offer(OP_COUNT, 5'd0);
      offer(OP_COUNT, 5'd0);
      offer(OP_COUNT, 5'd1);
      offer(OP_REGISTER, 5'd0);
      offer(OP_COUNT, 5'd1);
      offer(OP_COUNT, 5'd31);
      offer(OP_TICK, 5'd31);
      offer(OP_TICK, 5'd0);
      offer(OP_COUNT, 5'd1);
      wait_idle();

      // zero scale, pool grows slowly
      write_scale('0);
      @(negedge clock);
      phase_id = 2;
      offer_random(40, 8, 6);
      wait_idle();

      // largest scale and a back-to-back burst of counts on one channel
      write_scale({SCALE_BITS{1'b1}});
      @(negedge clock);
      phase_id = 3;
      sender_eager = 1'b1;
      rsp_eager = 1'b1;
      for (int k = 0; k < BURST_COUNTS; k++) offer(OP_COUNT, 5'd0);
      offer(OP_COUNT, 5'd1);
      offer(OP_TICK, 5'd0);
      wait_idle();
      sender_eager = 1'b0;
      rsp_eager = 1'b0;

      // top of the nominal range, then fill the pool and overflow it
      write_scale(10'd1000);
      @(negedge clock);
      phase_id = 4;
      offer_random(60, 12, 6);
      while (planned_claims < POOL) offer(OP_REGISTER, CHANNEL_BITS'($urandom));
      offer(OP_COUNT, 5'd31);
      offer(OP_REGISTER, 5'd31);
      offer(OP_REGISTER, 5'd0);
      offer(OP_TICK, 5'd0);
      wait_idle();

      // unit scale with a full pool, receiver holds off for a long stretch
      write_scale(10'd1);
      @(negedge clock);
      phase_id = 5;
      offer(OP_COUNT, 5'd3);
      offer(OP_COUNT, 5'd31);
      offer(OP_TICK, 5'd7);
      offer(OP_REGISTER, 5'd0);
      offer(OP_TICK, 5'd0);
      offer_random(80, 4, 5);
      wait_idle();

      // random scale, no idling on either side
      write_scale(SCALE_BITS'($urandom_range(2, 999)));
      @(negedge clock);
      phase_id = 6;
      sender_eager = 1'b1;
      rsp_eager = 1'b1;
      offer_random(40, 4, 8);
      wait_idle();

      $display("run covered %0d requests and %0d results over six scale settings",
               req_taken, rsp_seen);
      $display("pool filled to %0d channels with overflow claims and a count burst",
               planned_claims);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures, %0d results never arrived", fail_count, expected_rsp.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
